// File: rtl/core/cacp_pkg.sv
// Shared constants and types for the call auction clearing price block.
package cacp_pkg;

   localparam int ORDER_DEPTH_DEF = 1024;
   localparam int PRICE_BITS_DEF  = 32;
   localparam int QTY_BITS_DEF    = 32;

   // Clearing engine sequencer states
   typedef enum logic [2:0] {
      BK_IDLE,
      BK_LOAD,
      BK_SCAN,
      BK_DRAIN,
      BK_EVAL,
      BK_DONE
   } bk_state_type;

endpackage

// File: rtl/core/call_auction_clearing_price.sv
// Top level of the volume-maximizing call auction clearing price block.
// Orders load one per cycle, while req_full is low, into a store of
// ORDER_DEPTH entries; the order marked batch_last closes the batch and starts
// clearing, during which req_full stays high. Clearing evaluates each stored
// price as a candidate by reading the whole store through one shared read
// address, one order per inner read. The result sits in an output register
// until popped; one more batch may load meanwhile.
module call_auction_clearing_price #(
   parameter int ORDER_DEPTH = cacp_pkg::ORDER_DEPTH_DEF,
   parameter int PRICE_BITS  = cacp_pkg::PRICE_BITS_DEF,
   parameter int QTY_BITS    = cacp_pkg::QTY_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  logic                  req_order_is_buy,
   input  logic [PRICE_BITS-1:0] req_order_price,
   input  logic [QTY_BITS-1:0]   req_order_qty,
   input  logic                  req_batch_last,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output logic                  rsp_price_valid,
   output logic [PRICE_BITS-1:0] rsp_cross_price,
   output logic [QTY_BITS+$clog2(ORDER_DEPTH)-1:0] rsp_peak_volume,
   output logic                  rsp_orders_dropped
);

   import cacp_pkg::*;

   localparam int AW = $clog2(ORDER_DEPTH);
   localparam int CW = $clog2(ORDER_DEPTH + 1);

   logic                  st_wr_en;
   logic [AW-1:0]         st_wr_addr;
   logic [PRICE_BITS-1:0] st_wr_price;
   logic [QTY_BITS:0]     st_wr_side_qty;
   logic                  job_valid, job_dropped, job_take, back_busy;
   logic [CW-1:0]         job_count;
   logic [AW-1:0]         rd_addr_j, rd_addr_i;
   logic [PRICE_BITS-1:0] price_j, price_i;
   logic [QTY_BITS:0]     side_qty_j;

   cacp_front #(.ORDER_DEPTH(ORDER_DEPTH), .PRICE_BITS(PRICE_BITS), .QTY_BITS(QTY_BITS))
   u_front (
      .clock, .reset, .req_push, .req_full, .req_order_is_buy, .req_order_price,
      .req_order_qty, .req_batch_last, .st_wr_en, .st_wr_addr, .st_wr_price,
      .st_wr_side_qty, .job_valid, .job_count, .job_dropped, .job_take, .back_busy
   );

   // price store, two copies: inner scan and outer candidate
   cacp_ram #(.WIDTH(PRICE_BITS), .DEPTH(ORDER_DEPTH)) u_price_j (
      .clock, .wr_en(st_wr_en), .wr_addr(st_wr_addr), .wr_data(st_wr_price),
      .rd_addr(rd_addr_j), .rd_data(price_j)
   );

   cacp_ram #(.WIDTH(PRICE_BITS), .DEPTH(ORDER_DEPTH)) u_price_i (
      .clock, .wr_en(st_wr_en), .wr_addr(st_wr_addr), .wr_data(st_wr_price),
      .rd_addr(rd_addr_i), .rd_data(price_i)
   );

   // side flag and quantity store
   cacp_ram #(.WIDTH(QTY_BITS+1), .DEPTH(ORDER_DEPTH)) u_side_qty (
      .clock, .wr_en(st_wr_en), .wr_addr(st_wr_addr), .wr_data(st_wr_side_qty),
      .rd_addr(rd_addr_j), .rd_data(side_qty_j)
   );

   cacp_back #(.ORDER_DEPTH(ORDER_DEPTH), .PRICE_BITS(PRICE_BITS), .QTY_BITS(QTY_BITS))
   u_back (
      .clock, .reset, .job_valid, .job_count, .job_dropped, .job_take, .back_busy,
      .rd_addr_j, .rd_addr_i, .price_j, .side_qty_j, .price_i, .rsp_empty, .rsp_pop,
      .rsp_price_valid, .rsp_cross_price, .rsp_peak_volume, .rsp_orders_dropped
   );

   // price valid exactly when some volume executes
   assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_price_valid == (rsp_peak_volume != '0)))
      else $error("price_valid disagrees with peak volume");

   // no price reported without volume
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_price_valid) |-> (rsp_cross_price == '0))
      else $error("nonzero price on invalid result");

   // store must not take orders while it is being cleared
   assert property (@(posedge clock) disable iff (reset)
      back_busy |-> req_full)
      else $error("orders accepted during clearing");

   // a handed-off job leaves the front side blocked on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      job_take |=> back_busy)
      else $error("clear job taken but engine idle");

endmodule

// File: rtl/core/cacp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cacp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/cacp_front.sv
// Front end: accepts orders, writes the store, hands a clear job to the back end.
module cacp_front #(
   parameter int ORDER_DEPTH = cacp_pkg::ORDER_DEPTH_DEF,
   parameter int PRICE_BITS  = cacp_pkg::PRICE_BITS_DEF,
   parameter int QTY_BITS    = cacp_pkg::QTY_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_push,
   output logic                           req_full,
   input  logic                           req_order_is_buy,
   input  logic [PRICE_BITS-1:0]          req_order_price,
   input  logic [QTY_BITS-1:0]            req_order_qty,
   input  logic                           req_batch_last,
   output logic                           st_wr_en,
   output logic [$clog2(ORDER_DEPTH)-1:0] st_wr_addr,
   output logic [PRICE_BITS-1:0]          st_wr_price,
   output logic [QTY_BITS:0]              st_wr_side_qty,
   output logic                           job_valid,
   output logic [$clog2(ORDER_DEPTH+1)-1:0] job_count,
   output logic                           job_dropped,
   input  logic                           job_take,
   input  logic                           back_busy
);

   import cacp_pkg::*;

   localparam int AW = $clog2(ORDER_DEPTH);
   localparam int CW = $clog2(ORDER_DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(ORDER_DEPTH);

   logic [CW-1:0] count_ff, count_in;
   logic          drop_ff, drop_in;
   logic          job_valid_ff, job_valid_in;
   logic [CW-1:0] job_count_ff, job_count_in;
   logic          job_drop_ff, job_drop_in;
   logic          accept;
   logic          room;

   // Store is held while a batch waits to be cleared or is being cleared
   assign req_full = job_valid_ff | back_busy;
   assign accept   = req_push & ~req_full;
   assign room     = (count_ff < DEPTH_C);

   assign st_wr_en       = accept & room;
   assign st_wr_addr     = count_ff[AW-1:0];
   assign st_wr_price    = req_order_price;
   assign st_wr_side_qty = {req_order_is_buy, req_order_qty};

   // Fill count, drop flag and job handoff
   always_comb begin
      count_in     = count_ff;
      drop_in      = drop_ff;
      job_valid_in = job_valid_ff & ~job_take;
      job_count_in = job_count_ff;
      job_drop_in  = job_drop_ff;
      if (accept) begin
         if (room) begin
            count_in = count_ff + CW'(1);
         end else begin
            drop_in = 1'b1;
         end
         if (req_batch_last) begin
            job_valid_in = 1'b1;
            job_count_in = count_in;
            job_drop_in  = drop_in;
            count_in     = '0;
            drop_in      = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         drop_ff      <= 1'b0;
         job_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         drop_ff      <= drop_in;
         job_valid_ff <= job_valid_in;
      end
      job_count_ff <= job_count_in;
      job_drop_ff  <= job_drop_in;
   end

   assign job_valid   = job_valid_ff;
   assign job_count   = job_count_ff;
   assign job_dropped = job_drop_ff;

endmodule

// File: rtl/core/cacp_back.sv
// Back end: sweeps every candidate price over the store and holds the result.
module cacp_back #(
   parameter int ORDER_DEPTH = cacp_pkg::ORDER_DEPTH_DEF,
   parameter int PRICE_BITS  = cacp_pkg::PRICE_BITS_DEF,
   parameter int QTY_BITS    = cacp_pkg::QTY_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             job_valid,
   input  logic [$clog2(ORDER_DEPTH+1)-1:0] job_count,
   input  logic                             job_dropped,
   output logic                             job_take,
   output logic                             back_busy,
   output logic [$clog2(ORDER_DEPTH)-1:0]   rd_addr_j,
   output logic [$clog2(ORDER_DEPTH)-1:0]   rd_addr_i,
   input  logic [PRICE_BITS-1:0]            price_j,
   input  logic [QTY_BITS:0]                side_qty_j,
   input  logic [PRICE_BITS-1:0]            price_i,
   output logic                             rsp_empty,
   input  logic                             rsp_pop,
   output logic                             rsp_price_valid,
   output logic [PRICE_BITS-1:0]            rsp_cross_price,
   output logic [QTY_BITS+$clog2(ORDER_DEPTH)-1:0] rsp_peak_volume,
   output logic                             rsp_orders_dropped
);

   import cacp_pkg::*;

   localparam int AW = $clog2(ORDER_DEPTH);
   localparam int CW = $clog2(ORDER_DEPTH + 1);
   localparam int SW = QTY_BITS + $clog2(ORDER_DEPTH);

   bk_state_type state_ff, state_in;
   logic [CW-1:0]   n_ff, n_in;
   logic            drop_ff, drop_in;
   logic [AW-1:0]   i_ff, i_in, j_ff, j_in;
   logic            pend_ff, pend_in;
   logic [SW-1:0]   dem_ff, dem_in, sup_ff, sup_in;
   logic [SW-1:0]   best_ff, best_in;
   logic [PRICE_BITS-1:0] lo_ff, lo_in, hi_ff, hi_in;
   logic            out_valid_ff, out_valid_in;
   logic            out_pv_ff, out_pv_in;
   logic [PRICE_BITS-1:0] out_price_ff, out_price_in;
   logic [SW-1:0]   out_vol_ff, out_vol_in;
   logic            out_drop_ff, out_drop_in;
   logic [CW-1:0]   last_idx;
   logic [SW-1:0]   vol;
   logic [PRICE_BITS-1:0] mid;

   assign last_idx  = n_ff - CW'(1);
   assign vol       = (dem_ff < sup_ff) ? dem_ff : sup_ff;
   assign mid       = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign rd_addr_j = j_ff;
   assign rd_addr_i = i_ff;
   assign back_busy = (state_ff != BK_IDLE);

   // Sweep sequencer: outer index over candidates, inner index over orders
   always_comb begin
      state_in     = state_ff;
      n_in         = n_ff;
      drop_in      = drop_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      pend_in      = 1'b0;
      dem_in       = dem_ff;
      sup_in       = sup_ff;
      best_in      = best_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      job_take     = 1'b0;
      out_valid_in = out_valid_ff & ~rsp_pop;
      out_pv_in    = out_pv_ff;
      out_price_in = out_price_ff;
      out_vol_in   = out_vol_ff;
      out_drop_in  = out_drop_ff;

      // accumulate the order read in the previous cycle
      if (pend_ff) begin
         if (side_qty_j[QTY_BITS]) begin
            if (price_j >= price_i) begin
               dem_in = dem_ff + SW'(side_qty_j[QTY_BITS-1:0]);
            end
         end else begin
            if (price_j <= price_i) begin
               sup_in = sup_ff + SW'(side_qty_j[QTY_BITS-1:0]);
            end
         end
      end

      case (state_ff)
         BK_IDLE: begin
            if (job_valid) begin
               job_take = 1'b1;
               n_in     = job_count;
               drop_in  = job_dropped;
               i_in     = '0;
               best_in  = '0;
               lo_in    = '0;
               hi_in    = '0;
               state_in = BK_LOAD;
            end
         end
         BK_LOAD: begin
            j_in     = '0;
            dem_in   = '0;
            sup_in   = '0;
            state_in = BK_SCAN;
         end
         BK_SCAN: begin
            pend_in = 1'b1;
            j_in    = j_ff + AW'(1);
            if (CW'(j_ff) == last_idx) begin
               state_in = BK_DRAIN;
            end
         end
         BK_DRAIN: begin
            state_in = BK_EVAL;
         end
         BK_EVAL: begin
            if (vol > best_ff) begin
               best_in = vol;
               lo_in   = price_i;
               hi_in   = price_i;
            end else if (vol == best_ff) begin
               if (price_i < lo_ff) lo_in = price_i;
               if (price_i > hi_ff) hi_in = price_i;
            end
            i_in = i_ff + AW'(1);
            if (CW'(i_ff) == last_idx) begin
               state_in = BK_DONE;
            end else begin
               state_in = BK_LOAD;
            end
         end
         BK_DONE: begin
            if (~out_valid_ff | rsp_pop) begin
               out_valid_in = 1'b1;
               out_pv_in    = (best_ff != '0);
               out_price_in = (best_ff != '0) ? mid : '0;
               out_vol_in   = best_ff;
               out_drop_in  = drop_ff;
               state_in     = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         pend_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         out_valid_ff <= out_valid_in;
      end
      n_ff         <= n_in;
      drop_ff      <= drop_in;
      i_ff         <= i_in;
      j_ff         <= j_in;
      dem_ff       <= dem_in;
      sup_ff       <= sup_in;
      best_ff      <= best_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      out_pv_ff    <= out_pv_in;
      out_price_ff <= out_price_in;
      out_vol_ff   <= out_vol_in;
      out_drop_ff  <= out_drop_in;
   end

   assign rsp_empty          = ~out_valid_ff;
   assign rsp_price_valid    = out_pv_ff;
   assign rsp_cross_price    = out_price_ff;
   assign rsp_peak_volume    = out_vol_ff;
   assign rsp_orders_dropped = out_drop_ff;

endmodule
